FILE: src/cpvg_pkg.sv
// Shared constants and types for the polygon vertex generator pipeline.
package cpvg_pkg;

  localparam int NW         = 13;
  localparam int PH_W       = 32;
  localparam int Q_W        = 32;
  localparam int X_W        = 30;
  localparam int T_W        = 31;
  localparam int LANES      = 2;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = PH_W / DIV_BITS;
  localparam int HRN_STEPS  = 4;
  localparam int SC_STAGES  = 4 + 3 * HRN_STEPS;
  localparam int RQ_W       = 17;
  localparam int RCP_W      = 31;

  localparam logic [NW-1:0] N_MIN   = 13'd3;
  localparam logic [NW-1:0] N_RESET = 13'd32;

  localparam logic [31:0]    PI_Q30  = 32'hC90F_DAA2;
  localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam int SIN_DIV [HRN_STEPS] = '{72, 42, 20, 6};
  localparam int COS_DIV [HRN_STEPS] = '{90, 56, 30, 12};

  typedef struct packed {
    logic valid;
    logic idx_valid;
  } ctl_t;

endpackage

FILE: src/cpvg_phase_div.sv
// Pipelined long division producing the vertex phase and the half-step phase.
module cpvg_phase_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cpvg_pkg::ctl_t            ctl_in,
  input  logic [cpvg_pkg::NW-1:0]   n_eff,
  input  logic [cpvg_pkg::NW-1:0]   k_start,
  output cpvg_pkg::ctl_t            ctl_out,
  output logic [cpvg_pkg::PH_W-1:0] ph_out [cpvg_pkg::LANES]
);
  import cpvg_pkg::*;

  ctl_t            ctl_r [DIV_STAGES];
  logic [PH_W-1:0] num   [LANES];
  logic [NW-1:0]   start [LANES];

  function automatic logic [NW:0] div_step(input logic [NW-1:0] rem, input logic din,
                                           input logic [NW-1:0] d);
    logic [NW:0] sh;
    sh = {rem, din};
    if (sh >= {1'b0, d}) begin
      return {1'b1, NW'(sh - {1'b0, d})};
    end
    return {1'b0, sh[NW-1:0]};
  endfunction

  assign num[0]   = {{(PH_W - NW + 1){1'b0}}, n_eff[NW-1:1]};
  assign num[1]   = {1'b1, num[0][PH_W-2:0]};
  assign start[0] = k_start;
  assign start[1] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_ctl
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[s] <= '0;
        end else if (en) begin
          ctl_r[s] <= ctl_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[s] <= '0;
        end else if (en) begin
          ctl_r[s] <= ctl_r[s-1];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [NW-1:0]   rem_r [DIV_STAGES];
    logic [PH_W-1:0] quo_r [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [NW-1:0]       rem_in;
      logic [PH_W-1:0]     quo_in;
      logic [NW-1:0]       rem_nxt;
      logic [DIV_BITS-1:0] qb_nxt;

      if (s == 0) begin : g_first
        assign rem_in = start[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign quo_in = quo_r[s-1];
      end

      always_comb begin : p_step
        logic [NW:0] st;
        rem_nxt = rem_in;
        qb_nxt  = '0;
        for (int b = 0; b < DIV_BITS; b++) begin
          st = div_step(rem_nxt, num[l][PH_W - 1 - s * DIV_BITS - b], n_eff);
          rem_nxt = st[NW-1:0];
          qb_nxt[DIV_BITS-1-b] = st[NW];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          quo_r[s] <= {quo_in[PH_W-DIV_BITS-1:0], qb_nxt};
        end
      end
    end

    assign ph_out[l] = quo_r[DIV_STAGES-1];
  end

  assign ctl_out = ctl_r[DIV_STAGES-1];

endmodule

FILE: src/cpvg_sincos.sv
// Pipelined fixed point sine and cosine of a turn fraction, two lanes.
module cpvg_sincos (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  cpvg_pkg::ctl_t                  ctl_in,
  input  logic [cpvg_pkg::PH_W-1:0]       ph_in   [cpvg_pkg::LANES],
  output cpvg_pkg::ctl_t                  ctl_out,
  output logic signed [cpvg_pkg::Q_W-1:0] cos_out [cpvg_pkg::LANES],
  output logic signed [cpvg_pkg::Q_W-1:0] sin_out [cpvg_pkg::LANES]
);
  import cpvg_pkg::*;

  localparam int HRN_STAGES = 3 * HRN_STEPS;
  localparam int FIN_STAGE  = 2 + HRN_STAGES;

  typedef struct packed {
    logic [2:0]     oct;
    logic [X_W-1:0] x;
    logic [X_W-1:0] x2;
  } ang_t;

  typedef struct packed {
    logic [X_W-1:0] v;
    logic [X_W-1:0] q;
    logic [T_W-1:0] t;
  } hrn_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  localparam hrn_t HRN_INIT = '{v: '0, q: '0, t: ONE_Q30};

  ctl_t ctl_r [SC_STAGES];

  for (genvar j = 0; j < SC_STAGES; j++) begin : g_ctl
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[j] <= '0;
        end else if (en) begin
          ctl_r[j] <= ctl_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[j] <= '0;
        end else if (en) begin
          ctl_r[j] <= ctl_r[j-1];
        end
      end
    end
  end

  assign ctl_out = ctl_r[SC_STAGES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ang_t                  ang_r [FIN_STAGE+1];
    hrn_t                  hs_r  [HRN_STAGES];
    hrn_t                  hc_r  [HRN_STAGES];
    logic [T_W-1:0]        s0_r;
    logic [T_W-1:0]        c0_r;
    logic signed [Q_W-1:0] cos_r;
    logic signed [Q_W-1:0] sin_r;
    ang_t                  ang0_nxt;
    ang_t                  ang1_nxt;

    always_comb begin : p_reduce
      logic [X_W-1:0] f;
      logic [61:0]    xp;
      f = {1'b0, ph_in[l][28:0]};
      if (ph_in[l][29]) begin
        f = 30'h2000_0000 - f;
      end
      xp = 62'(f) * 62'(PI_Q30) + 62'h4000_0000;
      ang0_nxt     = '0;
      ang0_nxt.oct = ph_in[l][31:29];
      ang0_nxt.x   = xp[60:31];
    end

    always_comb begin : p_square
      logic [59:0] sq;
      sq = 60'(ang_r[0].x) * 60'(ang_r[0].x);
      ang1_nxt    = ang_r[0];
      ang1_nxt.x2 = sq[59:30];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ang_r[0] <= ang0_nxt;
        ang_r[1] <= ang1_nxt;
      end
    end

    for (genvar k = 0; k < HRN_STAGES; k++) begin : g_hrn
      localparam int             STEP = k / 3;
      localparam int             PHS  = k % 3;
      localparam int             DS   = SIN_DIV[STEP];
      localparam int             DC   = COS_DIV[STEP];
      localparam logic [X_W-1:0] MS   = X_W'((64'd1 << 32) / DS);
      localparam logic [X_W-1:0] MC   = X_W'((64'd1 << 32) / DC);

      hrn_t hs_in;
      hrn_t hc_in;
      hrn_t hs_nxt;
      hrn_t hc_nxt;

      if (k == 0) begin : g_first
        assign hs_in = HRN_INIT;
        assign hc_in = HRN_INIT;
      end else begin : g_next
        assign hs_in = hs_r[k-1];
        assign hc_in = hc_r[k-1];
      end

      always_comb begin : p_step
        logic [60:0] ps;
        logic [60:0] pc;
        logic [59:0] ms;
        logic [59:0] mc;
        logic [36:0] rs;
        logic [36:0] rc;
        hs_nxt = hs_in;
        hc_nxt = hc_in;
        ps = '0;
        pc = '0;
        ms = '0;
        mc = '0;
        rs = '0;
        rc = '0;
        case (PHS)
          0: begin
            ps = 61'(ang_r[k+1].x2) * 61'(hs_in.t);
            pc = 61'(ang_r[k+1].x2) * 61'(hc_in.t);
            hs_nxt.v = ps[59:30];
            hc_nxt.v = pc[59:30];
          end
          1: begin
            ms = 60'(hs_in.v) * 60'(MS);
            mc = 60'(hc_in.v) * 60'(MC);
            hs_nxt.q = X_W'(ms[59:32]);
            hc_nxt.q = X_W'(mc[59:32]);
          end
          default: begin
            rs = 37'(hs_in.v) - 37'(hs_in.q) * 37'(DS);
            rc = 37'(hc_in.v) - 37'(hc_in.q) * 37'(DC);
            hs_nxt.t = ONE_Q30 - T_W'(hs_in.q) - ((rs >= 37'(DS)) ? T_W'(1) : T_W'(0));
            hc_nxt.t = ONE_Q30 - T_W'(hc_in.q) - ((rc >= 37'(DC)) ? T_W'(1) : T_W'(0));
          end
        endcase
      end

      always_ff @(posedge clk) begin
        if (en) begin
          hs_r[k]    <= hs_nxt;
          hc_r[k]    <= hc_nxt;
          ang_r[k+2] <= ang_r[k+1];
        end
      end
    end

    always_ff @(posedge clk) begin : p_final
      logic [60:0] fs;
      logic [60:0] fc;
      fs = 61'(ang_r[FIN_STAGE-1].x) * 61'(hs_r[HRN_STAGES-1].t);
      fc = 61'(ang_r[FIN_STAGE-1].x2) * 61'(hc_r[HRN_STAGES-1].t);
      if (en) begin
        s0_r             <= T_W'(fs[59:30]);
        c0_r             <= ONE_Q30 - T_W'(fc[59:31]);
        ang_r[FIN_STAGE] <= ang_r[FIN_STAGE-1];
      end
    end

    always_ff @(posedge clk) begin : p_octant
      logic signed [Q_W-1:0] qc;
      logic signed [Q_W-1:0] qs;
      logic [2:0]            oct;
      oct = ang_r[FIN_STAGE].oct;
      qc  = oct[0] ? $signed(Q_W'(s0_r)) : $signed(Q_W'(c0_r));
      qs  = oct[0] ? $signed(Q_W'(c0_r)) : $signed(Q_W'(s0_r));
      if (en) begin
        unique case (quad_t'(oct[2:1]))
          QUAD_0: begin
            cos_r <= qc;
            sin_r <= qs;
          end
          QUAD_1: begin
            cos_r <= -qs;
            sin_r <= qc;
          end
          QUAD_2: begin
            cos_r <= -qc;
            sin_r <= -qs;
          end
          default: begin
            cos_r <= qs;
            sin_r <= -qc;
          end
        endcase
      end
    end

    assign cos_out[l] = cos_r;
    assign sin_out[l] = sin_r;
  end

endmodule

FILE: src/cpvg_recip.sv
// Pipelined rounded reciprocal of the half-step cosine, one quotient bit per stage.
module cpvg_recip (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [cpvg_pkg::Q_W-1:0] c_in,
  output logic [cpvg_pkg::RQ_W-1:0]       q_out,
  output logic                            nonpos_out
);
  import cpvg_pkg::*;

  logic [RCP_W-1:0] rem_r [RQ_W];
  logic [RCP_W-1:0] d_r   [RQ_W];
  logic [RQ_W-1:0]  lo_r  [RQ_W];
  logic [RQ_W-1:0]  q_r   [RQ_W];
  logic             np_r  [RQ_W];

  logic [RCP_W-1:0] rem0;

  assign rem0 = (RCP_W'(1) << (44 - RQ_W)) + RCP_W'(c_in[RCP_W-1:RQ_W+1]);

  for (genvar j = 0; j < RQ_W; j++) begin : g_stage
    logic [RCP_W-1:0] rem_in;
    logic [RCP_W-1:0] d_in;
    logic [RQ_W-1:0]  lo_in;
    logic [RQ_W-1:0]  q_in;
    logic             np_in;
    logic [RCP_W:0]   sh;
    logic             qb;
    logic [RCP_W-1:0] rem_nxt;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign d_in   = c_in[RCP_W-1:0];
      assign lo_in  = c_in[RQ_W:1];
      assign q_in   = '0;
      assign np_in  = c_in[Q_W-1] || (c_in == '0);
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign q_in   = q_r[j-1];
      assign np_in  = np_r[j-1];
    end

    assign sh      = {rem_in, lo_in[RQ_W-1-j]};
    assign qb      = sh >= {1'b0, d_in};
    assign rem_nxt = qb ? RCP_W'(sh - {1'b0, d_in}) : sh[RCP_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        d_r[j]   <= d_in;
        lo_r[j]  <= lo_in;
        q_r[j]   <= {q_in[RQ_W-2:0], qb};
        np_r[j]  <= np_in;
      end
    end
  end

  assign q_out      = q_r[RQ_W-1];
  assign nonpos_out = np_r[RQ_W-1];

endmodule

FILE: src/circle_polygon_vertex_generator.sv
// Top level of the regular polygon vertex generator.
//
//  port group | dir | payload
//  in_*       | in  | tdata[12:0] vertex_index
//  out_*      | out | tuser index_valid; tdata pos_x, pos_y, axis_x, axis_y, scale_factor
//  cfg_*      | in  | wr_data segment count
//
// One transaction per cycle unless out_tready stalls it; the pipeline holds 16 phase division
// stages, 16 sine and cosine stages, 17 reciprocal stages and an output register.
// Reset is synchronous: it clears every valid bit and sets the segment count to 32.
// out_tready low with a result waiting freezes all stages and drops in_tready.
module circle_polygon_vertex_generator #(
  parameter int unsigned MAX_VERTICES = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [15:0]             in_tdata,    // [12:0] vertex_index
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [79:0]             out_tdata,   // pos_x, pos_y, axis_x, axis_y, scale_factor
  output logic                    out_tuser,   // index_valid
  input  logic                    cfg_wr_en,
  input  logic [cpvg_pkg::NW-1:0] cfg_wr_data
);
  import cpvg_pkg::*;

  localparam int unsigned NCAP = (MAX_VERTICES < (1 << NW)) ? MAX_VERTICES : (1 << NW) - 1;
  localparam logic [NW-1:0] NMAX = NCAP[NW-1:0];

  function automatic logic [NW-1:0] clamp_n(input logic [NW-1:0] v);
    if (v < N_MIN) begin
      return N_MIN;
    end
    if (v > NMAX) begin
      return NMAX;
    end
    return v;
  endfunction

  function automatic logic [15:0] round_q14(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] r;
    mag = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
    r   = (mag + 32'h8000) >> 16;
    return v[Q_W-1] ? 16'(-r) : r[15:0];
  endfunction

  logic [NW-1:0]         n_eff_r;
  logic                  en;
  logic [NW-1:0]         k;
  ctl_t                  ctl_in;
  logic [NW-1:0]         k_start;
  ctl_t                  div_ctl;
  logic [PH_W-1:0]       ph [LANES];
  ctl_t                  sc_ctl;
  logic signed [Q_W-1:0] cs [LANES];
  logic signed [Q_W-1:0] sn [LANES];
  logic [RQ_W-1:0]       rq;
  logic                  rq_nonpos;

  ctl_t                  dl_ctl_r [RQ_W];
  logic [15:0]           px_r     [RQ_W];
  logic [15:0]           py_r     [RQ_W];

  logic                  out_tvalid_r;
  logic                  out_tuser_r;
  logic [79:0]           out_tdata_r;
  logic [15:0]           scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r <= clamp_n(N_RESET);
    end else if (cfg_wr_en) begin
      n_eff_r <= clamp_n(cfg_wr_data);
    end
  end

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  assign k                = in_tdata[NW-1:0];
  assign ctl_in.valid     = in_tvalid;
  assign ctl_in.idx_valid = k <= n_eff_r;
  assign k_start          = (k < n_eff_r) ? k : '0;

  cpvg_phase_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_in),
    .n_eff   (n_eff_r),
    .k_start (k_start),
    .ctl_out (div_ctl),
    .ph_out  (ph)
  );

  cpvg_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (div_ctl),
    .ph_in   (ph),
    .ctl_out (sc_ctl),
    .cos_out (cs),
    .sin_out (sn)
  );

  cpvg_recip u_recip (
    .clk        (clk),
    .en         (en),
    .c_in       (cs[1]),
    .q_out      (rq),
    .nonpos_out (rq_nonpos)
  );

  for (genvar j = 0; j < RQ_W; j++) begin : g_dly
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dl_ctl_r[j] <= '0;
        end else if (en) begin
          dl_ctl_r[j] <= sc_ctl;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          px_r[j] <= round_q14(cs[0]);
          py_r[j] <= round_q14(sn[0]);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dl_ctl_r[j] <= '0;
        end else if (en) begin
          dl_ctl_r[j] <= dl_ctl_r[j-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          px_r[j] <= px_r[j-1];
          py_r[j] <= py_r[j-1];
        end
      end
    end
  end

  assign scale = (rq_nonpos || rq[RQ_W-1]) ? 16'hFFFF : rq[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dl_ctl_r[RQ_W-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser_r <= dl_ctl_r[RQ_W-1].idx_valid;
      if (dl_ctl_r[RQ_W-1].idx_valid) begin
        out_tdata_r <= {scale, px_r[RQ_W-1], 16'(-py_r[RQ_W-1]), py_r[RQ_W-1], px_r[RQ_W-1]};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("out of range index gave nonzero fields");

  a_scale_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[79:64] >= 16'd16384)
    else $error("scale factor below one");

  a_axis_rot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (16'(out_tdata[47:32] + out_tdata[31:16]) == 16'd0) &&
      (out_tdata[63:48] == out_tdata[15:0]))
    else $error("chord direction not a rotation of the vertex");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_wr_en) |-> n_eff_r >= N_MIN && n_eff_r <= NMAX)
    else $error("segment count outside its range");

endmodule

FILE: verif/cpvg_checker.sv
// Checker for the polygon vertex generator: watches the channels, predicts results, compares.
`timescale 1ns / 100ps
module cpvg_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [15:0]             in_tdata,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [79:0]             out_tdata,
  input  logic                    out_tuser,
  input  logic                    cfg_wr_en,
  input  logic [cpvg_pkg::NW-1:0] cfg_wr_data,
  output int                      fail_count,
  output int                      pending_count
);
  import cpvg_pkg::*;

  typedef struct packed {
    logic        idx_ok;
    logic [15:0] scale;
    logic [15:0] ay;
    logic [15:0] ax;
    logic [15:0] py;
    logic [15:0] px;
  } vertex_t;

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  logic [NW-1:0] seg_count;
  vertex_t       vertex_q[$];

  function automatic void circle_q30(input logic [31:0] ph, output longint c_out,
                                     output longint s_out);
    logic [2:0]  oct;
    logic [63:0] f, x, x2, t, s0, c0;
    longint      qc, qs;
    oct = ph[31:29];
    f = {35'd0, ph[28:0]};
    if (oct[0]) f = (64'd1 << 29) - f;
    x = (f * 64'(PI_Q30) + (64'd1 << 30)) >> 31;
    x2 = (x * x) >> 30;
    t = ONE30 - x2 / 72;
    t = ONE30 - ((x2 * t) >> 30) / 42;
    t = ONE30 - ((x2 * t) >> 30) / 20;
    t = ONE30 - ((x2 * t) >> 30) / 6;
    s0 = (x * t) >> 30;
    t = ONE30 - x2 / 90;
    t = ONE30 - ((x2 * t) >> 30) / 56;
    t = ONE30 - ((x2 * t) >> 30) / 30;
    t = ONE30 - ((x2 * t) >> 30) / 12;
    c0 = ONE30 - ((x2 * t) >> 30) / 2;
    qc = oct[0] ? longint'(s0) : longint'(c0);
    qs = oct[0] ? longint'(c0) : longint'(s0);
    case (oct[2:1])
      2'd0: begin c_out = qc;  s_out = qs;  end
      2'd1: begin c_out = -qs; s_out = qc;  end
      2'd2: begin c_out = -qc; s_out = -qs; end
      default: begin c_out = qs; s_out = -qc; end
    endcase
  endfunction

  function automatic logic [15:0] to_q14(input longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + 32768) >>> 16;
    return 16'(v < 0 ? -m : m);
  endfunction

  function automatic vertex_t predict_vertex(input logic [NW-1:0] k_in);
    vertex_t     r;
    logic [63:0] n, k, ph, sc;
    longint      c, s;
    r = '0;
    n = seg_count < 3 ? 64'd3 : (seg_count > 4096 ? 64'd4096 : 64'(seg_count));
    k = 64'(k_in);
    if (k > n) return r;
    ph = ((k << 32) + n / 2) / n;
    circle_q30(ph[31:0], c, s);
    r.idx_ok = 1'b1;
    r.px = to_q14(c);
    r.py = to_q14(s);
    r.ax = -r.py;
    r.ay = r.px;
    ph = ((64'd1 << 31) + n / 2) / n;
    circle_q30(ph[31:0], c, s);
    if (c <= 0) sc = 65535;
    else begin
      sc = ((64'd1 << 44) + 64'(c) / 2) / 64'(c);
      if (sc > 65535) sc = 65535;
    end
    r.scale = sc[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_t want, got;
    if (!rst_n) begin
      seg_count <= N_RESET;
      vertex_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) seg_count <= cfg_wr_data;
      if (in_tvalid && in_tready) vertex_q.push_back(predict_vertex(in_tdata[NW-1:0]));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (vertex_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = vertex_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: valid %b/%b px %h/%h py %h/%h ax %h/%h ay %h/%h sc %h/%h",
                       want.idx_ok, got.idx_ok, want.px, got.px, want.py, got.py,
                       want.ax, got.ax, want.ay, got.ay, want.scale, got.scale);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = vertex_q.size();
  end
endmodule

FILE: verif/testbench.sv
// Top of the polygon vertex generator testbench: stimulus, configuration phases, verdict.
`timescale 1ns / 100ps
module testbench;
  import cpvg_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [15:0]   in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [79:0]   out_tdata;
  logic          out_tuser;
  logic          cfg_wr_en;
  logic [NW-1:0] cfg_wr_data;
  int            fail_count;
  int            pending_count;
  int            idle_cycles;
  bit            hold_out;
  logic [NW-1:0] cur_n;

  circle_polygon_vertex_generator dut (.*);
  cpvg_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_index(input logic [NW-1:0] k);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_count(input logic [NW-1:0] n);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    cur_n = n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [NW-1:0] pick_index();
    int r;
    int eff;
    eff = cur_n < 3 ? 3 : (cur_n > 4096 ? 4096 : cur_n);
    r = $urandom_range(0, 9);
    if (r == 0) return NW'($urandom_range(0, 8191));
    if (r == 1) return NW'(eff);
    if (r == 2 && eff < 8191) return NW'($urandom_range(eff + 1, 8191));
    return NW'($urandom_range(0, eff));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) hold_out <= 1'b0;
    else if (hold_out) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready || out_tvalid && out_tready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [NW-1:0] dir_k[$];
    logic [NW-1:0] counts[$];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_cycles = 0;
    cur_n = N_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dir_k = '{0, 1, 8, 16, 24, 31, 32, 33, 8191, 4096, 5, 4, 12, 20, 28};
    foreach (dir_k[i]) send_index(dir_k[i]);
    drain_results();
    counts = '{3, 4096, 0, 2, 8191, 4097, 6, 7, 100, 1000};
    foreach (counts[c]) begin
      set_count(counts[c]);
      send_index(0);
      send_index(counts[c]);
      send_index(8191);
      repeat (35) send_index(pick_index());
      drain_results();
    end
    set_count(13'd17);
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
      repeat (80) send_index(pick_index());
    join
    drain_results();
    set_count(13'd5);
    repeat (40) send_index(pick_index());
    drain_results();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
src/cpvg_pkg.sv
src/cpvg_phase_div.sv
src/cpvg_sincos.sv
src/cpvg_recip.sv
src/circle_polygon_vertex_generator.sv
verif/cpvg_checker.sv
verif/testbench.sv
